[hdl/gdsa_pkg.sv]
package gdsa_pkg;

    localparam int GROUPS     = 1024;
    localparam int GRP_AW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GROUP_W    = 10;
    localparam int COUNT_BITS = 40;
    localparam int PCOUNT_W   = 40;
    localparam int SUM_W      = 256;
    localparam int HALF_W     = SUM_W / 2;
    localparam int CFG_AW     = 2;
    localparam int CFG_DW     = 32;
    localparam int MINC_W     = 32;

    // saturating count add works one bit wider than either operand
    localparam int CSUM_W = ((COUNT_BITS > PCOUNT_W) ? COUNT_BITS : PCOUNT_W) + 1;
    // count vs row floor compare width
    localparam int CCMP_W = (COUNT_BITS > MINC_W) ? COUNT_BITS : MINC_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // action codes
    localparam logic [1:0] ACT_ROW   = 2'd0;
    localparam logic [1:0] ACT_MERGE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // config register indexes
    localparam logic [CFG_AW-1:0] REG_SKIP_NULLS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_ROW_FLOOR  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_IN_WIDE    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_OUT_WIDE   = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [GROUP_W-1:0]  group;
        logic                value_valid;
        logic [63:0]         value_w0;
        logic [63:0]         value_w1;
        logic [63:0]         value_w2;
        logic [63:0]         value_w3;
        logic [PCOUNT_W-1:0] partial_count;
        logic                partial_null;
    } t_in_word;

    typedef struct packed {
        logic [GROUP_W-1:0] out_group;
        logic               result_null;
        logic [63:0]        sum_w0;
        logic [63:0]        sum_w1;
        logic [63:0]        sum_w2;
        logic [63:0]        sum_w3;
    } t_out_word;

    // one table row: seen-null flag, row count, 256-bit sum
    typedef struct packed {
        logic                  flag;
        logic [COUNT_BITS-1:0] cnt;
        logic [SUM_W-1:0]      sum;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [GRP_AW-1:0] addr;
        t_entry            data;
    } t_wr_req;

endpackage

[hdl/gdsa_ifs.sv]
interface gdsa_in_if;
    import gdsa_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdsa_out_if;
    import gdsa_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdsa_cfg_if;
    import gdsa_pkg::*;

    logic              valid;
    logic              ready;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[hdl/gdsa_table.sv]
module gdsa_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [gdsa_pkg::GRP_AW-1:0]   i_rd_addr,
    output gdsa_pkg::t_entry              o_rd_data,
    input  gdsa_pkg::t_wr_req             i_wr,
    output logic                          o_busy
);
    import gdsa_pkg::*;

    t_entry            r_mem [GROUPS];
    t_entry            r_rd_data;
    logic              r_busy;
    logic [GRP_AW-1:0] r_clr_addr;
    t_wr_req           w_wr;

    // clear sweep owns the write port until done
    always_comb begin
        if (r_busy) begin
            w_wr.en   = 1'b1;
            w_wr.addr = r_clr_addr;
            w_wr.data = '0;
        end else begin
            w_wr = i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr.en) begin
            r_mem[w_wr.addr] <= w_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == GRP_AW'(GROUPS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

[hdl/grouped_decimal_sum_accumulator_core.sv]
// A read result passes the table read register, then the output register. Row and
// merge words go through table read, low-half add and high-half add with write-back;
// read words through table read and read-out, held while the output stalls.
// Reset (sync, active low) starts a clear sweep of the group table; no input word
// is taken until it ends. Config writes are taken at any time.
module grouped_decimal_sum_accumulator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdsa_in_if.sink    i_in,
    gdsa_out_if.source o_out,
    gdsa_cfg_if.sink   i_cfg
);
    import gdsa_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a word
    localparam logic [1:0] S_WAIT = 2'd1;   // table read data valid, low half / read out
    localparam logic [1:0] S_HI   = 2'd2;   // high half add and write-back

    logic [1:0] r_state, n_state;

    // config registers
    logic              r_skip_nulls;
    logic [MINC_W-1:0] r_row_floor;
    logic              r_in_wide;
    logic              r_out_wide;

    // captured word
    logic [1:0]          r_op;
    logic [GROUP_W-1:0]  r_grp;
    logic                r_inr;
    logic [SUM_W-1:0]    r_add;
    logic [PCOUNT_W-1:0] r_cadd;
    logic                r_fset;

    // low-half results carried into the high-half step
    logic [HALF_W-1:0]     r_lo_sum;
    logic                  r_carry;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_flag;

    // output register
    logic      r_out_vld;
    t_out_word r_out;

    // table port
    logic    w_busy;
    logic    w_accept;
    t_entry  w_rd;
    t_entry  w_entry;
    t_wr_req w_wr;

    logic                     w_inr_in;
    logic [SUM_W-1:0]         w_add_in;
    logic [PCOUNT_W-1:0]      w_cadd_in;
    logic                     w_fset_in;
    logic [HALF_W:0]          w_lo;
    logic [HALF_W-1:0]        w_hi;
    logic [CSUM_W-1:0]        w_csum;
    logic [COUNT_BITS-1:0]    w_cnt_next;
    logic                     w_is_null;
    logic                     w_out_free;

    gdsa_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (i_in.data.group[GRP_AW-1:0]),
        .o_rd_data (w_rd),
        .i_wr      (w_wr),
        .o_busy    (w_busy)
    );

    // ---------------- config port ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_nulls <= 1'b1;
            r_row_floor  <= MINC_W'(1);
            r_in_wide    <= 1'b0;
            r_out_wide   <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                REG_SKIP_NULLS: r_skip_nulls <= i_cfg.data[0];
                REG_ROW_FLOOR:  r_row_floor  <= i_cfg.data[MINC_W-1:0];
                REG_IN_WIDE:    r_in_wide    <= i_cfg.data[0];
                REG_OUT_WIDE:   r_out_wide   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input capture ----------------
    assign i_in.ready = (r_state == S_IDLE) && !w_busy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_inr_in   = 32'(i_in.data.group) < 32'(GROUPS);

    // addend, count increment and flag set, decided at accept
    always_comb begin
        w_add_in  = '0;
        w_cadd_in = '0;
        w_fset_in = 1'b0;
        unique case (i_in.data.action)
            ACT_ROW: begin
                if (i_in.data.value_valid) begin
                    w_cadd_in = PCOUNT_W'(1);
                    if (r_in_wide) begin
                        w_add_in = {i_in.data.value_w3, i_in.data.value_w2,
                                    i_in.data.value_w1, i_in.data.value_w0};
                    end else begin
                        // 128-bit row value, sign-extended
                        w_add_in = {{HALF_W{i_in.data.value_w1[63]}},
                                    i_in.data.value_w1, i_in.data.value_w0};
                    end
                end else begin
                    w_fset_in = !r_skip_nulls;
                end
            end
            ACT_MERGE: begin
                w_add_in  = {i_in.data.value_w3, i_in.data.value_w2,
                             i_in.data.value_w1, i_in.data.value_w0};
                w_cadd_in = i_in.data.partial_count;
                w_fset_in = i_in.data.partial_null;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_in.data.action;
            r_grp  <= i_in.data.group;
            r_inr  <= w_inr_in;
            r_add  <= w_add_in;
            r_cadd <= w_cadd_in;
            r_fset <= w_fset_in;
        end
    end

    // ---------------- read-modify-write datapath ----------------
    // an out-of-range group reads as an empty entry
    assign w_entry = r_inr ? w_rd : '0;

    assign w_lo   = {1'b0, w_entry.sum[HALF_W-1:0]} + {1'b0, r_add[HALF_W-1:0]};
    assign w_csum = CSUM_W'(w_entry.cnt) + CSUM_W'(r_cadd);
    assign w_cnt_next = (w_csum > CSUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                      : w_csum[COUNT_BITS-1:0];
    assign w_hi = w_entry.sum[SUM_W-1:HALF_W] + r_add[SUM_W-1:HALF_W]
                  + HALF_W'(r_carry);

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT) begin
            r_lo_sum <= w_lo[HALF_W-1:0];
            r_carry  <= w_lo[HALF_W];
            r_cnt    <= w_cnt_next;
            r_flag   <= w_entry.flag | r_fset;
        end
    end

    always_comb begin
        w_wr.en        = (r_state == S_HI);
        w_wr.addr      = r_grp[GRP_AW-1:0];
        w_wr.data.flag = r_flag;
        w_wr.data.cnt  = r_cnt;
        w_wr.data.sum  = {w_hi, r_lo_sum};
    end

    // ---------------- read out ----------------
    assign w_is_null  = (!r_skip_nulls && w_entry.flag)
                        || (CCMP_W'(w_entry.cnt) < CCMP_W'(r_row_floor));
    assign w_out_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_WAIT) && (r_op == ACT_READ) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_WAIT) && (r_op == ACT_READ) && w_out_free) begin
            r_out.out_group   <= r_grp;
            r_out.result_null <= w_is_null;
            if (w_is_null) begin
                r_out.sum_w0 <= '0;
                r_out.sum_w1 <= '0;
                r_out.sum_w2 <= '0;
                r_out.sum_w3 <= '0;
            end else begin
                r_out.sum_w0 <= w_entry.sum[63:0];
                r_out.sum_w1 <= w_entry.sum[127:64];
                r_out.sum_w2 <= r_out_wide ? w_entry.sum[191:128] : 64'd0;
                r_out.sum_w3 <= r_out_wide ? w_entry.sum[255:192] : 64'd0;
            end
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (r_op == ACT_READ) begin
                    // hold here while the output word is stalled
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (r_inr && ((r_op == ACT_ROW) || (r_op == ACT_MERGE))) begin
                    n_state = S_HI;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HI: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
